// ===== rtl/core/rpe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the recurrence polynomial evaluator.
`timescale 1ns / 1ps

package rpe_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS     = 28;
  localparam int MAX_ORDER_DEF = 16;
  localparam int ORDER_WIDTH   = 4;
  localparam int INDEX_WIDTH   = 4;

  typedef logic signed [DATA_WIDTH-1:0]   fx_t;
  typedef logic signed [2*DATA_WIDTH-1:0] fx_wide_t;

  localparam fx_t FX_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fx_t FX_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam fx_t FX_ZERO = '0;
  localparam fx_t FX_ONE  = (FRAC_BITS >= DATA_WIDTH - 1) ? FX_MAX :
                            fx_t'(fx_t'(1) << FRAC_BITS);

  // Input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Multiply/accumulate phase of one general recurrence step
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_T_CV,    // product t * P_k
    MUL_B_PV,    // take t * P_k, product b * P_{k-1}
    MUL_T_CS,    // finish value, product t * P'_k
    MUL_B_PS,    // start slope, product b * P'_{k-1}
    MUL_FINISH   // finish slope
  } mul_op_t;

  // Source of the committed result
  typedef enum logic [1:0] {
    COMMIT_ORDER0,
    COMMIT_ORDER1,
    COMMIT_GENERAL
  } commit_sel_t;

  typedef struct packed {
    logic        wr_coef;
    logic        start_eval;
    logic        load_shift;
    mul_op_t     op;
    logic        commit;
    commit_sel_t sel;
  } rpe_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
    logic first;
  } rpe_status_t;

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // Floor-shift an exact product back to the fixed-point grid and saturate.
  function automatic fx_t fx_scale(input fx_wide_t p);
    fx_wide_t q;
    logic     fits;
    q    = p >>> FRAC_BITS;
    fits = (&q[2*DATA_WIDTH-1:DATA_WIDTH-1]) | ~(|q[2*DATA_WIDTH-1:DATA_WIDTH-1]);
    if (!fits) begin
      return q[2*DATA_WIDTH-1] ? FX_MIN : FX_MAX;
    end
    return q[DATA_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/core/rpe_if.sv =====
// Handshake interfaces for the input item and result channels.
`timescale 1ns / 1ps

interface rpe_in_if;
  import rpe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [INDEX_WIDTH-1:0] entry_index;
  fx_t                    coef_shift;
  fx_t                    coef_scale;
  fx_t                    point;

  modport source(output valid, kind, entry_index, coef_shift, coef_scale, point,
                 input ready);
  modport sink(input valid, kind, entry_index, coef_shift, coef_scale, point,
               output ready);
endinterface

interface rpe_out_if;
  import rpe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ORDER_WIDTH-1:0] order;
  fx_t                    value;
  fx_t                    slope;
  logic                   last;

  modport source(output valid, order, value, slope, last, input ready);
  modport sink(input valid, order, value, slope, last, output ready);
endinterface

// ===== rtl/core/rpe_datapath.sv =====
// Datapath: coefficient memory, recurrence registers, shared multiplier and result register.
`timescale 1ns / 1ps

module rpe_datapath import rpe_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpe_cmd_t               cmd,
  output rpe_status_t            st,
  input  logic [INDEX_WIDTH-1:0] in_entry_index,
  input  fx_t                    in_coef_shift,
  input  fx_t                    in_coef_scale,
  input  fx_t                    in_point,
  input  logic                   cfg_wr_en,
  input  logic [ORDER_WIDTH-1:0] cfg_wr_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [ORDER_WIDTH-1:0] out_order,
  output fx_t                    out_value,
  output fx_t                    out_slope,
  output logic                   out_last
);

  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ORDER_CAP = (2 ** ORDER_WIDTH) - 1;
  localparam logic [ORDER_WIDTH-1:0] TOP_ORDER =
    ORDER_WIDTH'((MAX_ORDER - 1 > ORDER_CAP) ? ORDER_CAP : MAX_ORDER - 1);

  logic [2*DATA_WIDTH-1:0] coef_mem [MAX_ORDER];
  logic [2*DATA_WIDTH-1:0] coef_rd_r;
  logic [AW-1:0]           rd_addr;
  logic [ORDER_WIDTH-1:0]  k_dec;
  logic                    wr_hit;

  logic [ORDER_WIDTH-1:0]  degree_r;
  logic [ORDER_WIDTH-1:0]  n_r;
  logic [ORDER_WIDTH-1:0]  k_r;
  fx_t x_r, t_r, b_r;
  fx_t cur_v_r, prev_v_r, cur_s_r, prev_s_r;
  fx_t acc_v_r, acc_s_r;
  fx_wide_t prod_r;

  fx_t      rd_shift, rd_scale;
  fx_t      mul_a, mul_b;
  fx_wide_t prod_nxt;
  fx_t      prod_sat;
  fx_t      new_v, new_s;

  logic                   out_valid_r;
  logic [ORDER_WIDTH-1:0] out_order_r;
  fx_t                    out_value_r, out_slope_r;
  logic                   out_last_r;

  // Coefficient table: one write port, one registered read port
  assign wr_hit  = cmd.wr_coef && (32'(in_entry_index) < MAX_ORDER);
  assign k_dec   = k_r - ORDER_WIDTH'(1);
  assign rd_addr = AW'(k_dec);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      coef_mem[AW'(in_entry_index)] <= {in_coef_shift, in_coef_scale};
    end
    coef_rd_r <= coef_mem[rd_addr];
  end

  assign rd_shift = coef_rd_r[2*DATA_WIDTH-1:DATA_WIDTH];
  assign rd_scale = coef_rd_r[DATA_WIDTH-1:0];

  // Shared multiplier operand select
  always_comb begin
    case (cmd.op)
      MUL_B_PV: begin
        mul_a = b_r;
        mul_b = prev_v_r;
      end
      MUL_T_CS: begin
        mul_a = t_r;
        mul_b = cur_s_r;
      end
      MUL_B_PS: begin
        mul_a = b_r;
        mul_b = prev_s_r;
      end
      default: begin
        mul_a = t_r;
        mul_b = cur_v_r;
      end
    endcase
  end

  assign prod_nxt = fx_wide_t'(mul_a) * fx_wide_t'(mul_b);
  assign prod_sat = fx_scale(prod_r);

  always_comb begin
    case (cmd.sel)
      COMMIT_ORDER0: begin
        new_v = FX_ONE;
        new_s = FX_ZERO;
      end
      COMMIT_ORDER1: begin
        new_v = t_r;
        new_s = FX_ONE;
      end
      default: begin
        new_v = acc_v_r;
        new_s = acc_s_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        degree_r <= cfg_wr_data;
      end
      if (cmd.start_eval) begin
        n_r <= (degree_r > TOP_ORDER) ? TOP_ORDER : degree_r;
        k_r <= '0;
      end else if (cmd.commit) begin
        k_r <= k_r + ORDER_WIDTH'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Recurrence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r  <= FX_ZERO;
      prev_v_r <= FX_ZERO;
      cur_s_r  <= FX_ZERO;
      prev_s_r <= FX_ZERO;
    end else if (cmd.start_eval) begin
      cur_v_r  <= FX_ZERO;
      prev_v_r <= FX_ZERO;
      cur_s_r  <= FX_ZERO;
      prev_s_r <= FX_ZERO;
    end else if (cmd.commit) begin
      prev_v_r <= cur_v_r;
      cur_v_r  <= new_v;
      prev_s_r <= cur_s_r;
      cur_s_r  <= new_s;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      x_r <= in_point;
    end
    if (cmd.load_shift) begin
      t_r <= fx_sub(x_r, rd_shift);
      b_r <= rd_scale;
    end
    if (cmd.op == MUL_T_CV || cmd.op == MUL_B_PV || cmd.op == MUL_T_CS ||
        cmd.op == MUL_B_PS) begin
      prod_r <= prod_nxt;
    end
    case (cmd.op)
      MUL_B_PV:   acc_v_r <= prod_sat;
      MUL_T_CS:   acc_v_r <= fx_sub(acc_v_r, prod_sat);
      MUL_B_PS:   acc_s_r <= fx_add(cur_v_r, prod_sat);
      MUL_FINISH: acc_s_r <= fx_sub(acc_s_r, prod_sat);
      default: ;
    endcase
    if (cmd.commit) begin
      out_order_r <= k_r;
      out_value_r <= new_v;
      out_slope_r <= new_s;
      out_last_r  <= (k_r == n_r);
    end
  end

  assign st.out_free = !out_valid_r || out_ready;
  assign st.last     = (k_r == n_r);
  assign st.first    = (k_r == ORDER_WIDTH'(1));

  assign out_valid = out_valid_r;
  assign out_order = out_order_r;
  assign out_value = out_value_r;
  assign out_slope = out_slope_r;
  assign out_last  = out_last_r;

  a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not load the result register");

  a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_order_r == $past(k_r))
    else $error("result order does not match the step counter");

endmodule

// ===== rtl/core/rpe_ctrl.sv =====
// Sequencer: accepts items and steps the datapath through each recurrence order.
`timescale 1ns / 1ps

module rpe_ctrl import rpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  input  rpe_status_t st,
  output rpe_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ORDER0,
    S_READ,
    S_SHIFT,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_EVAL) begin
            cmd.start_eval = 1'b1;
            state_nxt      = S_ORDER0;
          end else begin
            cmd.wr_coef = 1'b1;
          end
        end
      end
      S_ORDER0: begin
        cmd.sel = COMMIT_ORDER0;
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = st.last ? S_IDLE : S_READ;
        end
      end
      S_READ: state_nxt = S_SHIFT;
      S_SHIFT: begin
        cmd.load_shift = 1'b1;
        state_nxt      = st.first ? S_WRITE : S_M1;
      end
      S_M1: begin
        cmd.op    = MUL_T_CV;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = MUL_B_PV;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = MUL_T_CS;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.op    = MUL_B_PS;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.op    = MUL_FINISH;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.sel = st.first ? COMMIT_ORDER1 : COMMIT_GENERAL;
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = st.last ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> st.out_free)
    else $error("commit while the result register is occupied");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && st.last |=> state_r == S_IDLE && in_ready_r)
    else $error("sequencer did not return to idle after the last order");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE && !cmd.commit && cmd.op == MUL_NONE)
    else $error("input ready while a step is in progress");

endmodule

// ===== rtl/core/recurrence_polynomial_evaluator_unit.sv =====
// Top level of the three-term recurrence polynomial evaluator.
`timescale 1ns / 1ps

// Evaluates monic orthogonal polynomials by the three-term recurrence
// P_{k+1} = (x - a_k) P_k - b_k P_{k-1} together with the derivative
// recurrence, in signed Q3.28 with floor-rounded, saturating products and
// saturating sums. A transaction on in_item with kind = 0 writes the pair
// (coef_shift, coef_scale) = (a_k, b_k) into table entry entry_index
// (an index beyond the table is dropped) and yields no result. A transaction
// with kind = 1 evaluates at point and yields degree + 1 result transactions
// on out_result, order 0 upward, with last set on the highest order; entries
// 0 .. degree-1 must have been written before. degree is taken from
// cfg_wr_data when cfg_wr_en is high, and must only change while the unit is
// idle. Write transactions are accepted back to back. An evaluation commits
// order 0 directly; order 1 takes a table read, a shift subtract and a
// commit, and every higher order takes a table read, a shift subtract, four
// passes through the single shared 32x32 multiplier, a finishing subtract
// and a commit. A degree above MAX_ORDER - 1 is clamped to it. A new
// item is accepted in the cycle after the last result is committed, while
// that result may still wait in the output register. Stalls on out_result
// hold the sequencer at its commit step.
module recurrence_polynomial_evaluator_unit import rpe_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [ORDER_WIDTH-1:0] cfg_wr_data,
  rpe_in_if.sink                 in_item,
  rpe_out_if.source              out_result
);

  rpe_cmd_t    cmd;
  rpe_status_t st;

  // Sequencer: owns the input handshake and the step schedule
  rpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_kind  (in_item.kind),
    .in_ready (in_item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: table, recurrence registers, multiplier, result register
  rpe_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_entry_index (in_item.entry_index),
    .in_coef_shift  (in_item.coef_shift),
    .in_coef_scale  (in_item.coef_scale),
    .in_point       (in_item.point),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_ready      (out_result.ready),
    .out_valid      (out_result.valid),
    .out_order      (out_result.order),
    .out_value      (out_result.value),
    .out_slope      (out_result.slope),
    .out_last       (out_result.last)
  );

endmodule
